@@ hw/rtl/ihs_pkg.sv @@
package ihs_pkg;

    // Line store depth in pixels; the store holds MAX_WIDTH/2 pixel pairs.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int FW_W   = 12;                    // frame_width field
    localparam int FH_W   = 13;                    // frame_height field
    localparam int MODE_W = 2;
    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH) > FW_W ? $clog2(MAX_WIDTH) : FW_W;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PAIR_W = $clog2(MAX_WIDTH) - 1; // pair address bits
    localparam int CMP_W  = 14;                    // common width for bound compares
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RST = FH_W'(480);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_FLOOR = 2'd0,
        MODE_CEIL  = 2'd1,
        MODE_SUM4  = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

endpackage

@@ hw/rtl/image_half_sample_2x2_top.sv @@
// 2x2 box down-sampler for an 8-bit grey raster stream: one pixel is accepted
// per clock and one averaged pixel is produced at every odd column of every odd
// row, so the output is half as wide and half as high; an odd last column or
// row is consumed without a result. The even row is kept as pixel pairs in a
// single-port line store with a registered read, issued on the even column of
// the odd row so the pair is ready for the odd column that follows.
// Throughput is one item per cycle; input only stalls when a result would be
// produced while the previous result is still not taken. A write to the width,
// height or mode register restarts the frame at row 0, column 0. Rounding:
// mode 0 cascaded floor, mode 1 cascaded round-up (vertical first), mode 2
// floor of the four-sum, mode 3 as mode 0. No clearing pass: a block is only
// read after its row was stored in the same frame.
module image_half_sample_2x2_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ihs_pkg::PIX_W-1:0]         i_pixel_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ihs_pkg::PIX_W-1:0]         o_pixel_out,
    output logic                              o_row_end,
    output logic                              o_frame_end,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ihs_pkg::ADDR_W-1:0]        paddr,
    input  logic [ihs_pkg::DATA_W-1:0]        pwdata,
    output logic [ihs_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int CW = ihs_pkg::CMP_W;

    logic [ihs_pkg::FW_W-1:0]   r_width;
    logic [ihs_pkg::FH_W-1:0]   r_height;
    ihs_pkg::t_mode             r_mode;
    logic [ihs_pkg::COL_W-1:0]  r_col, n_col;
    logic [ihs_pkg::ROW_W-1:0]  r_row, n_row;
    logic [ihs_pkg::PIX_W-1:0]  r_held;
    logic [2*ihs_pkg::PIX_W-1:0] r_pair;
    logic                       r_out_valid;
    logic [ihs_pkg::PIX_W-1:0]  r_out_pix;
    logic                       r_out_re, r_out_fe;

    logic [2*ihs_pkg::PIX_W-1:0] line_mem [ihs_pkg::MAX_WIDTH/2];

    ihs_pkg::t_reg_idx          cfg_idx;
    logic                       cfg_wr;
    logic [CW-1:0]              w_eff, h_eff, w_even, h_even, col_x, row_x;
    logic                       active, emit, accept, re, fe;
    logic [ihs_pkg::PAIR_W-1:0] pair_addr;
    logic [ihs_pkg::PIX_W-1:0]  tl, tr, bl, br, avg;
    logic [ihs_pkg::PIX_W+1:0]  s_a, s_b, s_o;

    assign pready  = 1'b1;
    assign cfg_idx = ihs_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            ihs_pkg::REG_WIDTH:  prdata = ihs_pkg::DATA_W'(r_width);
            ihs_pkg::REG_HEIGHT: prdata = ihs_pkg::DATA_W'(r_height);
            ihs_pkg::REG_MODE:   prdata = ihs_pkg::DATA_W'(r_mode);
            default:             prdata = '0;
        endcase
    end

    // Clamp the frame size to the supported range.
    always_comb begin
        w_eff = CW'(r_width);
        if (w_eff < CW'(2))                  w_eff = CW'(2);
        if (w_eff > CW'(ihs_pkg::MAX_WIDTH)) w_eff = CW'(ihs_pkg::MAX_WIDTH);
        h_eff = CW'(r_height);
        if (h_eff < CW'(2))                   h_eff = CW'(2);
        if (h_eff > CW'(ihs_pkg::MAX_HEIGHT)) h_eff = CW'(ihs_pkg::MAX_HEIGHT);
    end

    assign w_even    = {w_eff[CW-1:1], 1'b0};
    assign h_even    = {h_eff[CW-1:1], 1'b0};
    assign col_x     = CW'(r_col);
    assign row_x     = CW'(r_row);
    assign active    = (row_x < h_even) && (col_x < w_even);
    assign emit      = active && r_row[0] && r_col[0];
    assign pair_addr = r_col[ihs_pkg::PAIR_W:1];
    assign re        = (col_x == w_even - CW'(1));
    assign fe        = re && (row_x == h_even - CW'(1));

    // Stall input only when this item yields a result and the output is full.
    assign o_ready = !(r_out_valid && !i_ready && emit);
    assign accept  = i_valid && o_ready;

    assign tl = r_pair[ihs_pkg::PIX_W-1:0];
    assign tr = r_pair[2*ihs_pkg::PIX_W-1:ihs_pkg::PIX_W];
    assign bl = r_held;
    assign br = i_pixel_in;

    always_comb begin
        s_a = '0;
        s_b = '0;
        s_o = '0;
        case (r_mode)
            ihs_pkg::MODE_CEIL: begin
                s_a = ((10'(tl) + 10'(bl) + 10'd1) >> 1);
                s_b = ((10'(tr) + 10'(br) + 10'd1) >> 1);
                s_o = (s_a + s_b + 10'd1) >> 1;
            end
            ihs_pkg::MODE_SUM4: begin
                s_o = (10'(tl) + 10'(tr) + 10'(bl) + 10'(br)) >> 2;
            end
            default: begin
                s_a = (10'(tl) + 10'(tr)) >> 1;
                s_b = (10'(bl) + 10'(br)) >> 1;
                s_o = (s_a + s_b) >> 1;
            end
        endcase
        avg = s_o[ihs_pkg::PIX_W-1:0];
    end

    // Advance the raster position, wrapping at the end of row and frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_x + CW'(1) >= w_eff) begin
            n_col = '0;
            if (row_x + CW'(1) >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = r_row + ihs_pkg::ROW_W'(1);
            end
        end else begin
            n_col = r_col + ihs_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= ihs_pkg::WIDTH_RST;
            r_height    <= ihs_pkg::HEIGHT_RST;
            r_mode      <= ihs_pkg::MODE_FLOOR;
            r_col       <= '0;
            r_row       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && cfg_idx != ihs_pkg::REG_NONE) begin
                case (cfg_idx)
                    ihs_pkg::REG_WIDTH:  r_width  <= pwdata[ihs_pkg::FW_W-1:0];
                    ihs_pkg::REG_HEIGHT: r_height <= pwdata[ihs_pkg::FH_W-1:0];
                    ihs_pkg::REG_MODE:   r_mode   <= ihs_pkg::t_mode'(pwdata[1:0]);
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept && active && !r_col[0]) begin
                r_held <= i_pixel_in;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line store: write the pair on the odd column of an even row, read it on
    // the even column of the odd row.
    always_ff @(posedge i_clk) begin
        if (accept && active && !r_row[0] && r_col[0]) begin
            line_mem[pair_addr] <= {i_pixel_in, r_held};
        end
        if (accept && active && r_row[0] && !r_col[0]) begin
            r_pair <= line_mem[pair_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_pix <= avg;
            r_out_re  <= re;
            r_out_fe  <= fe;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_row_end   = r_out_re;
    assign o_frame_end = r_out_fe;

endmodule

@@ hw/rtl/ihs_checker.sv @@
module ihs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [ihs_pkg::PIX_W-1:0] o_pixel_out,
    input logic                      o_row_end,
    input logic                      o_frame_end,
    input logic                      pready
);

    // A frame always ends on the last pixel of an output row.
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind image_half_sample_2x2_top ihs_checker u_ihs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pixel_out (o_pixel_out),
    .o_row_end   (o_row_end),
    .o_frame_end (o_frame_end),
    .pready      (pready)
);

@@ sim/tb_image_half_sample_2x2_top.sv @@
module tb_image_half_sample_2x2_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // Corner pixels (tl, tr, bl, br) for one 2x2 frame per rounding mode.
    localparam logic [ihs_pkg::PIX_W-1:0] CORNER_PX [16] = '{
        8'd255, 8'd255, 8'd255, 8'd255,
        8'd0,   8'd1,   8'd0,   8'd0,
        8'd255, 8'd254, 8'd0,   8'd1,
        8'd1,   8'd0,   8'd0,   8'd0
    };

    typedef struct packed {
        logic [ihs_pkg::PIX_W-1:0] pixel;
        logic                      row_end;
        logic                      frame_end;
    } t_block_result;

    class half_sample_scoreboard;
        logic [ihs_pkg::PIX_W-1:0] even_row [ihs_pkg::MAX_WIDTH];
        logic [ihs_pkg::PIX_W-1:0] held_left = '0;
        int unsigned               col = 0;
        int unsigned               row = 0;
        logic [ihs_pkg::FW_W-1:0]  width_reg  = ihs_pkg::WIDTH_RST;
        logic [ihs_pkg::FH_W-1:0]  height_reg = ihs_pkg::HEIGHT_RST;
        ihs_pkg::t_mode            mode_reg   = ihs_pkg::MODE_FLOOR;
        t_block_result             expected_q [$];
        int                        mismatches = 0;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void write_reg(ihs_pkg::t_reg_idx idx, logic [ihs_pkg::DATA_W-1:0] value);
            case (idx)
                ihs_pkg::REG_WIDTH:  width_reg  = value[ihs_pkg::FW_W-1:0];
                ihs_pkg::REG_HEIGHT: height_reg = value[ihs_pkg::FH_W-1:0];
                ihs_pkg::REG_MODE:
                    mode_reg = ihs_pkg::t_mode'(value[ihs_pkg::MODE_W-1:0]);
                default:    return;
            endcase
            // any real register write restarts the frame
            col = 0;
            row = 0;
        endfunction

        function logic [ihs_pkg::DATA_W-1:0] reg_value(ihs_pkg::t_reg_idx idx);
            case (idx)
                ihs_pkg::REG_WIDTH:  return ihs_pkg::DATA_W'(width_reg);
                ihs_pkg::REG_HEIGHT: return ihs_pkg::DATA_W'(height_reg);
                ihs_pkg::REG_MODE:   return ihs_pkg::DATA_W'(mode_reg);
                default:             return '0;
            endcase
        endfunction

        function void check_reg(ihs_pkg::t_reg_idx idx, logic [ihs_pkg::DATA_W-1:0] got);
            if (got !== reg_value(idx)) begin
                flag($sformatf("register %s read: expected %0h, got %0h",
                               idx.name(), reg_value(idx), got));
            end
        endfunction

        function logic [ihs_pkg::PIX_W-1:0] block_mean(int unsigned tl, int unsigned tr,
                                                       int unsigned bl, int unsigned br);
            int unsigned first_pair;
            int unsigned second_pair;
            case (mode_reg)
                ihs_pkg::MODE_CEIL: begin
                    first_pair  = (tl + bl + 1) >> 1;
                    second_pair = (tr + br + 1) >> 1;
                    return ihs_pkg::PIX_W'((first_pair + second_pair + 1) >> 1);
                end
                ihs_pkg::MODE_SUM4: begin
                    return ihs_pkg::PIX_W'((tl + tr + bl + br) >> 2);
                end
                default: begin
                    first_pair  = (tl + tr) >> 1;
                    second_pair = (bl + br) >> 1;
                    return ihs_pkg::PIX_W'((first_pair + second_pair) >> 1);
                end
            endcase
        endfunction

        function void accept_pixel(logic [ihs_pkg::PIX_W-1:0] px);
            int unsigned   w;
            int unsigned   h;
            int unsigned   w_even;
            int unsigned   h_even;
            t_block_result res;
            w = width_reg;
            h = height_reg;
            if (w < 2) w = 2;
            if (w > ihs_pkg::MAX_WIDTH) w = ihs_pkg::MAX_WIDTH;
            if (h < 2) h = 2;
            if (h > ihs_pkg::MAX_HEIGHT) h = ihs_pkg::MAX_HEIGHT;
            w_even = w & ~32'd1;
            h_even = h & ~32'd1;
            // odd last column or row falls through without a result
            if (row < h_even && col < w_even) begin
                if (row % 2 == 0) begin
                    even_row[col] = px;
                end else if (col % 2 == 0) begin
                    held_left = px;
                end else begin
                    res.pixel     = block_mean(even_row[col-1], even_row[col], held_left,
                                               px);
                    res.row_end   = (col == w_even - 1);
                    res.frame_end = res.row_end && (row == h_even - 1);
                    expected_q.push_back(res);
                end
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_result(logic [ihs_pkg::PIX_W-1:0] pixel, logic row_end,
                                   logic frame_end);
            t_block_result want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: pixel %0d row_end %0b frame_end %0b",
                               pixel, row_end, frame_end));
                return;
            end
            want = expected_q.pop_front();
            if (pixel !== want.pixel || row_end !== want.row_end
                    || frame_end !== want.frame_end) begin
                flag($sformatf({"result mismatch: expected pixel %0d row_end %0b ",
                                "frame_end %0b, got pixel %0d row_end %0b frame_end %0b"},
                               want.pixel, want.row_end, want.frame_end,
                               pixel, row_end, frame_end));
            end
        endfunction
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_ready;
    logic [ihs_pkg::PIX_W-1:0]    i_pixel_in  = '0;
    logic                         o_valid;
    logic                         i_ready     = 1'b0;
    logic [ihs_pkg::PIX_W-1:0]    o_pixel_out;
    logic                         o_row_end;
    logic                         o_frame_end;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [ihs_pkg::ADDR_W-1:0]   paddr       = '0;
    logic [ihs_pkg::DATA_W-1:0]   pwdata      = '0;
    logic [ihs_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    half_sample_scoreboard sb = new;

    image_half_sample_2x2_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAIL image_half_sample_2x2_top");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // check the result first: it always belongs to an older item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result(o_pixel_out, o_row_end, o_frame_end);
            end
            if (i_valid && o_ready) begin
                sb.accept_pixel(i_pixel_in);
            end
        end
    end

    function automatic logic [ihs_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ihs_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic set_pressure(int sel);
        case (sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    task automatic send_pixel(logic [ihs_pkg::PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic feed_pixels(int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    // drop valid, drain all expected results, then let the pipeline settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(ihs_pkg::t_reg_idx idx, logic [ihs_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(ihs_pkg::t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_reg(idx, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits of each write carry noise that the register must drop
    task automatic set_frame(int unsigned w, int unsigned h, ihs_pkg::t_mode mode);
        wait_idle();
        apb_write(ihs_pkg::REG_WIDTH, ($urandom << ihs_pkg::FW_W) | w);
        apb_write(ihs_pkg::REG_HEIGHT, ($urandom << ihs_pkg::FH_W) | h);
        apb_write(ihs_pkg::REG_MODE, ($urandom << ihs_pkg::MODE_W) | mode);
        apb_read_check(ihs_pkg::REG_WIDTH);
        apb_read_check(ihs_pkg::REG_HEIGHT);
        apb_read_check(ihs_pkg::REG_MODE);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_pressure(0);
        apb_read_check(ihs_pkg::REG_WIDTH);
        apb_read_check(ihs_pkg::REG_HEIGHT);
        apb_read_check(ihs_pkg::REG_MODE);

        for (int m = 0; m < 4; m++) begin
            set_frame(2, 2, ihs_pkg::t_mode'(m));
            for (int k = 0; k < 4; k++) send_pixel(CORNER_PX[m*4 + k]);
        end

        // odd width and height; pause mid-frame and poke the unused address
        set_frame(3, 3, ihs_pkg::MODE_CEIL);
        feed_pixels(4);
        wait_idle();
        apb_write(ihs_pkg::REG_NONE, $urandom);
        feed_pixels(5);

        for (int p = 0; p < 16; p++) begin
            int unsigned w;
            int unsigned h;
            int          n;
            set_pressure(p);
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 7);
            n = $urandom_range(25, 55);
            if (p == 0) begin
                w = 0;
                h = 1;
            end
            if (p == 1) begin
                w = 1;
                h = 0;
            end
            if (p == 14) begin
                w = 4095;
                h = 2;
                n = 60;
            end
            if (p == 15) begin
                w = 2;
                h = 8191;
                n = 60;
            end
            set_frame(w, h, ihs_pkg::t_mode'($urandom_range(0, 3)));
            feed_pixels(n);
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS image_half_sample_2x2_top");
        end else begin
            $display("FAIL image_half_sample_2x2_top");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ihs_pkg.sv
hw/rtl/image_half_sample_2x2_top.sv
hw/rtl/ihs_checker.sv
sim/tb_image_half_sample_2x2_top.sv
